// File: hdl/mixed_sign_int8_int4_dot_product_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the mixed-sign dot product block
// Shared concurrent assertion forms: same-cycle and next-cycle implication.
// ---------------------------------------------------------------------------
`ifndef MIXED_SIGN_INT8_INT4_DOT_PRODUCT_TOP_DEFINES_SVH
`define MIXED_SIGN_INT8_INT4_DOT_PRODUCT_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSDP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msdp assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define MSDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msdp assertion failed: next-cycle implication");

`endif

// File: hdl/msdp_pkg.sv
// ---------------------------------------------------------------------------
// msdp_pkg
// Types and fixed constants shared by the dot product lanes and merge stage.
// ---------------------------------------------------------------------------
package msdp_pkg;

   // Width of the fixed input words in bytes; lanes above this see zero bytes
   localparam int INPUT_BYTES = 8;
   localparam int BYTE_W      = 8;
   localparam int NIBBLE_BITS = 4;
   localparam int COUNT_W     = 5;
   localparam int ELEM_IDX_W  = 7;
   localparam int ACC_W       = 64;

   // One lane's contribution: 255 * -128 and two nibble products both fit
   localparam int PROD_W = 16;

   localparam logic FORMAT_BYTE   = 1'b0;
   localparam logic FORMAT_NIBBLE = 1'b1;

   typedef logic signed [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic                advance;
      logic                nibble_mode;
      logic [COUNT_W-1:0]  valid_count;
   } lane_ctrl_type;

endpackage

// File: hdl/msdp_lane.sv
// ---------------------------------------------------------------------------
// msdp_lane
// One byte lane: a 9x8 signed multiply in byte mode or two 5x4 multiplies in
// nibble mode, masked by the element count, result registered.
// ---------------------------------------------------------------------------
module msdp_lane #(
   parameter int LANE_INDEX = 0
) (
   input  logic                                 clock,
   input  msdp_pkg::lane_ctrl_type              ctrl,
   input  logic [msdp_pkg::BYTE_W-1:0]          u_byte,
   input  logic [msdp_pkg::BYTE_W-1:0]          s_byte,
   output msdp_pkg::prod_type                   product_ff
);

   localparam int IW = msdp_pkg::ELEM_IDX_W;
   localparam int PW = msdp_pkg::PROD_W;
   localparam int NB = msdp_pkg::NIBBLE_BITS;

   localparam logic [IW-1:0] BYTE_ELEM   = IW'(LANE_INDEX);
   localparam logic [IW-1:0] NIB_LO_ELEM = IW'(2 * LANE_INDEX);
   localparam logic [IW-1:0] NIB_HI_ELEM = IW'(2 * LANE_INDEX + 1);

   logic [IW-1:0]         count_ext;
   logic signed [16:0]    byte_full;
   logic signed [8:0]     nib_lo;
   logic signed [8:0]     nib_hi;
   msdp_pkg::prod_type    nib_lo_ext;
   msdp_pkg::prod_type    nib_hi_ext;
   msdp_pkg::prod_type    product_in;

   assign count_ext = {{(IW-msdp_pkg::COUNT_W){1'b0}}, ctrl.valid_count};

   assign byte_full = $signed({1'b0, u_byte}) * $signed(s_byte);
   assign nib_lo    = $signed({1'b0, u_byte[NB-1:0]}) * $signed(s_byte[NB-1:0]);
   assign nib_hi    = $signed({1'b0, u_byte[2*NB-1:NB]}) * $signed(s_byte[2*NB-1:NB]);

   assign nib_lo_ext = (count_ext > NIB_LO_ELEM) ? {{(PW-9){nib_lo[8]}}, nib_lo} : '0;
   assign nib_hi_ext = (count_ext > NIB_HI_ELEM) ? {{(PW-9){nib_hi[8]}}, nib_hi} : '0;

   always_comb begin
      if (ctrl.nibble_mode == msdp_pkg::FORMAT_NIBBLE) begin
         product_in = nib_lo_ext + nib_hi_ext;
      end else begin
         product_in = (count_ext > BYTE_ELEM) ? byte_full[PW-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         product_ff <= product_in;
      end
   end

endmodule

// File: hdl/msdp_merge.sv
// ---------------------------------------------------------------------------
// msdp_merge
// Adder tree over all lane products; the word sum is registered.
// ---------------------------------------------------------------------------
module msdp_merge #(
   parameter int WORD_BYTES = 8,
   parameter int SUM_W      = 20
) (
   input  logic                     clock,
   input  logic                     advance,
   input  msdp_pkg::prod_type       lane_product [WORD_BYTES],
   output logic signed [SUM_W-1:0]  word_sum_ff
);

   localparam int PW     = msdp_pkg::PROD_W;
   localparam int LEVELS = $clog2(WORD_BYTES);
   localparam int TREE_N = 1 << LEVELS;

   logic signed [SUM_W-1:0] tree [LEVELS+1][TREE_N];
   logic signed [SUM_W-1:0] word_sum_in;

   always_comb begin
      for (int l = 0; l <= LEVELS; l++) begin
         for (int i = 0; i < TREE_N; i++) begin
            tree[l][i] = '0;
         end
      end
      for (int i = 0; i < WORD_BYTES; i++) begin
         tree[0][i] = {{(SUM_W-PW){lane_product[i][PW-1]}}, lane_product[i]};
      end
      for (int l = 0; l < LEVELS; l++) begin
         for (int i = 0; i < (TREE_N >> (l + 1)); i++) begin
            tree[l+1][i] = tree[l][2*i] + tree[l][2*i+1];
         end
      end
      word_sum_in = tree[LEVELS][0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_sum_ff <= word_sum_in;
      end
   end

endmodule

// File: hdl/mixed_sign_int8_int4_dot_product_top.sv
// ---------------------------------------------------------------------------
// mixed_sign_int8_int4_dot_product_top
// Unsigned-by-signed dot product accumulator, byte or nibble elements.
// ---------------------------------------------------------------------------
//   channel   direction   ports                         beat carries
//   req       in          req_valid / req_ready         one word pair, count, last mark
//   rsp       out         rsp_valid / rsp_ready         exact 64-bit dot sum
//   csr       in          csr_write_enable              element format bit
//
// One beat per cycle while req_ready is high; a result becomes valid after its last beat
// passes the lane multiply, merge tree and accumulator/output registers.
// Reset clears the accumulator, element format and all stage valids.
// A stalled result holds only the last-marked beat in the merge stage; other
// beats keep flowing into the accumulator behind a waiting result.
// ---------------------------------------------------------------------------
`include "mixed_sign_int8_int4_dot_product_top_defines.svh"

module mixed_sign_int8_int4_dot_product_top #(
   parameter int WORD_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_unsigned_word,
   input  logic [63:0] req_signed_word,
   input  logic [4:0]  req_valid_elements,
   input  logic        req_last_word,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_dot_sum,

   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   localparam int PW    = msdp_pkg::PROD_W;
   localparam int BW    = msdp_pkg::BYTE_W;
   localparam int AW    = msdp_pkg::ACC_W;
   localparam int SUM_W = PW + $clog2(WORD_BYTES + 1);

   logic                    format_ff;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_last_ff;
   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_last_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [AW-1:0]    rsp_sum_ff;
   logic [AW-1:0]           running_sum_ff, running_sum_in;

   logic                    out_free;
   logic                    s2_ready;
   logic                    s1_ready;
   logic                    s2_fire;
   logic [AW-1:0]           acc_total;

   msdp_pkg::lane_ctrl_type lane_ctrl;
   msdp_pkg::prod_type      lane_product [WORD_BYTES];
   logic signed [SUM_W-1:0] word_sum;

   // Backpressure chain: a non-last beat in the merge stage never waits
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s2_ready = !s2_valid_ff || !s2_last_ff || out_free;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s2_fire  = s2_valid_ff && s2_ready;

   assign req_ready   = s1_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_dot_sum = rsp_sum_ff;

   assign lane_ctrl.advance     = s1_ready;
   assign lane_ctrl.nibble_mode = format_ff;
   assign lane_ctrl.valid_count = req_valid_elements;

   for (genvar k = 0; k < WORD_BYTES; k++) begin : g_lane
      logic [BW-1:0] u_byte;
      logic [BW-1:0] s_byte;

      if (k < msdp_pkg::INPUT_BYTES) begin : g_live
         assign u_byte = req_unsigned_word[BW*k +: BW];
         assign s_byte = req_signed_word[BW*k +: BW];
      end else begin : g_pad
         assign u_byte = '0;
         assign s_byte = '0;
      end

      msdp_lane #(
         .LANE_INDEX (k)
      ) u_lane (
         .clock      (clock),
         .ctrl       (lane_ctrl),
         .u_byte     (u_byte),
         .s_byte     (s_byte),
         .product_ff (lane_product[k])
      );
   end

   msdp_merge #(
      .WORD_BYTES (WORD_BYTES),
      .SUM_W      (SUM_W)
   ) u_merge (
      .clock        (clock),
      .advance      (s2_ready),
      .lane_product (lane_product),
      .word_sum_ff  (word_sum)
   );

   assign acc_total = running_sum_ff + {{(AW-SUM_W){word_sum[SUM_W-1]}}, word_sum};

   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      running_sum_in = running_sum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (s2_fire) begin
         if (s2_last_ff) begin
            running_sum_in = '0;
            rsp_valid_in   = 1'b1;
         end else begin
            running_sum_in = acc_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff      <= msdp_pkg::FORMAT_BYTE;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         running_sum_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            format_ff <= csr_write_data;
         end
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         running_sum_ff <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_last_ff <= req_last_word;
      end
      if (s2_ready) begin
         s2_last_ff <= s1_last_ff;
      end
      if (s2_fire && s2_last_ff) begin
         rsp_sum_ff <= acc_total;
      end
   end

   `MSDP_ASSERT_NEXT(a_last_emits, clock, reset, s2_fire && s2_last_ff, rsp_valid_ff)
   `MSDP_ASSERT_NEXT(a_last_clears, clock, reset, s2_fire && s2_last_ff, running_sum_ff == '0)
   `MSDP_ASSERT_SAME(a_stall_needs_beat, clock, reset, !req_ready, s1_valid_ff && s2_valid_ff)

endmodule
